// File: design/rgp_pkg.sv
// Shared constants, types and helpers for the radial gradient pixel core.
package rgp_pkg;

	localparam int MAX_DIM    = 1024;
	localparam int PIX_W      = 10;
	localparam int CFG_DIM_W  = 11;
	localparam int COLOR_W    = 24;
	localparam int OFFSET_W   = 8;
	localparam int CH_W       = 8;
	localparam int NCH        = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam int DIM_W   = $clog2(MAX_DIM) + 1;
	localparam int DCLMP_W = (CFG_DIM_W > DIM_W) ? CFG_DIM_W : DIM_W;
	localparam int R_W     = $clog2(MAX_DIM);
	localparam int DX_W    = (PIX_W > R_W) ? PIX_W : R_W;
	localparam int SQ1_W   = 2 * DX_W;
	localparam int D2_W    = SQ1_W + 1;
	localparam int R2_W    = 2 * R_W;
	localparam int DCMP_W  = (D2_W > R2_W) ? D2_W : R2_W;
	localparam int FSQ_W   = 16;
	localparam int TGT_W   = R2_W + FSQ_W;
	localparam int WR_W    = R_W + CH_W;
	localparam int WSQ_W   = 2 * WR_W;
	localparam int CMP_W   = (TGT_W > WSQ_W) ? TGT_W : WSQ_W;
	localparam int SUM_W   = 2 * CH_W;
	localparam int QUO_W   = SUM_W + 1;

	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);

	localparam logic [FSQ_W-1:0] FULL_SQ     = FSQ_W'(65025);
	localparam logic [CH_W-1:0]  CH_MAX      = '1;
	localparam logic [CH_W-1:0]  ALPHA_OPQ   = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 3'd0,
		REG_IMAGE_HEIGHT = 3'd1,
		REG_START_COLOR  = 3'd2,
		REG_END_COLOR    = 3'd3,
		REG_ROUND_OFFSET = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [R2_W-1:0] d2;
		logic [R_W-1:0]  r;
		logic            sat;
	} dist_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// clamp a dimension to MAX_DIM and return its floor half
	function automatic logic [R_W-1:0] half_dim(input logic [CFG_DIM_W-1:0] v);
		logic [DCLMP_W-1:0] ext;
		logic [DCLMP_W-1:0] lim;
		ext = DCLMP_W'(v);
		lim = DCLMP_W'(MAX_DIM);
		if (ext > lim) begin
			ext = lim;
		end
		return R_W'(ext >> 1);
	endfunction

endpackage

// File: design/radial_gradient_pixel_core.sv
// Radial gradient pixel core: one RGBA colour per pixel coordinate transaction.
// Path: front end, queue, weight search of eight stages (most of the depth), mix registers.
// Throughput: one pixel per cycle unless out_ready low holds the output register.
// A four-entry queue decouples the front end from the back end, so either side stalls alone.
// Reset: registers return to 320, 240, 0, 0xFFFFFF, 0 and all pipelines empty; no clearing pass.
module radial_gradient_pixel_core import rgp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [PIX_W-1:0]      pixel_x,
	input  logic [PIX_W-1:0]      pixel_y,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [CH_W-1:0]       red,
	output logic [CH_W-1:0]       green,
	output logic [CH_W-1:0]       blue,
	output logic [CH_W-1:0]       alpha
);

	logic [CFG_DIM_W-1:0] image_width_q, image_height_q;
	logic [COLOR_W-1:0]   outer_rgb_q, inner_rgb_q;
	logic [OFFSET_W-1:0]  round_offset_q;

	q_stat_t         qs;
	logic            push, pop, back_en;
	dist_t           push_data, head;
	logic            w_valid;
	logic [CH_W-1:0] w;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= CFG_DIM_W'(320);
			image_height_q <= CFG_DIM_W'(240);
			outer_rgb_q    <= '0;
			inner_rgb_q    <= '1;
			round_offset_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[CFG_DIM_W-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data[CFG_DIM_W-1:0];
				REG_START_COLOR:  outer_rgb_q    <= cfg_data[COLOR_W-1:0];
				REG_END_COLOR:    inner_rgb_q    <= cfg_data[COLOR_W-1:0];
				REG_ROUND_OFFSET: round_offset_q <= cfg_data[OFFSET_W-1:0];
				default: begin
				end
			endcase
		end
	end

	rgp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.image_width  (image_width_q),
		.image_height (image_height_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.qs           (qs),
		.push         (push),
		.push_data    (push_data)
	);

	rgp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_data),
		.pop    (pop),
		.dout   (head),
		.qs     (qs)
	);

	// whole back end advances together unless the output register is held
	assign back_en = !out_valid || out_ready;
	assign pop     = back_en && !qs.empty;

	rgp_weight u_weight (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (back_en),
		.in_valid  (!qs.empty),
		.din       (head),
		.out_valid (w_valid),
		.w         (w)
	);

	rgp_mix u_mix (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (back_en),
		.in_valid        (w_valid),
		.w               (w),
		.outer_rgb       (outer_rgb_q),
		.inner_rgb       (inner_rgb_q),
		.rounding_offset (round_offset_q),
		.out_valid       (out_valid),
		.red             (red),
		.green           (green),
		.blue            (blue)
	);

	assign alpha = ALPHA_OPQ;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && qs.full))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && qs.empty))
		else $error("queue read while empty");

	a_front_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(qs.full && !pop) |=> !qs.empty)
		else $error("full queue drained without a pop");

endmodule

// File: design/rgp_front.sv
// Front end: takes pixel transactions, forms squared distance and radius, flags saturation.
module rgp_front import rgp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [CFG_DIM_W-1:0] image_width,
	input  logic [CFG_DIM_W-1:0] image_height,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [PIX_W-1:0]     pixel_x,
	input  logic [PIX_W-1:0]     pixel_y,
	input  q_stat_t              qs,
	output logic                 push,
	output dist_t                push_data
);

	logic [R_W-1:0]    cx, cy, r;
	logic [DX_W-1:0]   cx_e, cy_e, px_e, py_e, dx, dy;
	logic              en;
	logic              v_s1, v_s2;
	logic [DX_W-1:0]   dx_s1, dy_s1;
	logic [R_W-1:0]    r_s1, r_s2;
	logic [SQ1_W-1:0]  dxsq_s2, dysq_s2;
	logic [R2_W-1:0]   rsq_s2;
	logic [D2_W-1:0]   d2;

	assign cx   = half_dim(image_width);
	assign cy   = half_dim(image_height);
	assign r    = (cx < cy) ? cx : cy;
	assign cx_e = DX_W'(cx);
	assign cy_e = DX_W'(cy);
	assign px_e = DX_W'(pixel_x);
	assign py_e = DX_W'(pixel_y);
	assign dx   = (cx_e > px_e) ? (cx_e - px_e) : (px_e - cx_e);
	assign dy   = (cy_e > py_e) ? (cy_e - py_e) : (py_e - cy_e);

	assign en       = !(v_s2 && qs.full);
	assign in_ready = en;
	assign push     = v_s2 && !qs.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1   <= dx;
			dy_s1   <= dy;
			r_s1    <= r;
			dxsq_s2 <= SQ1_W'(dx_s1) * SQ1_W'(dx_s1);
			dysq_s2 <= SQ1_W'(dy_s1) * SQ1_W'(dy_s1);
			rsq_s2  <= R2_W'(r_s1) * R2_W'(r_s1);
			r_s2    <= r_s1;
		end
	end

	assign d2 = D2_W'(dxsq_s2) + D2_W'(dysq_s2);

	// d2 only matters when it does not exceed r*r, so the narrower copy is exact
	assign push_data.d2  = R2_W'(d2);
	assign push_data.r   = r_s2;
	assign push_data.sat = (r_s2 == '0) || (DCMP_W'(d2) > DCMP_W'(rsq_s2));

endmodule

// File: design/rgp_queue.sv
// Short queue between the front end and the weight pipeline.
module rgp_queue import rgp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  dist_t   din,
	input  logic    pop,
	output dist_t   dout,
	output q_stat_t qs
);

	dist_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			priority if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	assign dout     = mem_q[rd_ptr_q];
	assign qs.full  = (count_q == (QPTR_W+1)'(QDEPTH));
	assign qs.empty = (count_q == '0);

endmodule

// File: design/rgp_weight.sv
// Blend weight: exact floor(255*sqrt(d2)/r), one weight bit decided per pipeline stage.
module rgp_weight import rgp_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  dist_t           din,
	output logic            out_valid,
	output logic [CH_W-1:0] w
);

	logic            v_s   [0:CH_W];
	logic            sat_s [0:CH_W];
	logic [CH_W-1:0] wt_s  [0:CH_W];
	logic [WR_W-1:0] wr_s  [0:CH_W-1];
	logic [TGT_W-1:0] tgt_s [0:CH_W-1];
	logic [R_W-1:0]  r_s   [0:CH_W-1];

	// entry stage: target = 65025*d2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tgt_s[0] <= TGT_W'(FULL_SQ) * TGT_W'(din.d2);
			r_s[0]   <= din.r;
			sat_s[0] <= din.sat;
			wt_s[0]  <= '0;
			wr_s[0]  <= '0;
		end
	end

	for (genvar k = 0; k < CH_W; k++) begin : g_bit
		localparam int B = CH_W - 1 - k;
		logic [WR_W-1:0]  cand;
		logic [WSQ_W-1:0] sq;
		logic             ok;

		// wr tracks wt*r, so trying the next bit is an add, not a multiply
		assign cand = wr_s[k] + (WR_W'(r_s[k]) << B);
		assign sq   = WSQ_W'(cand) * WSQ_W'(cand);
		assign ok   = CMP_W'(sq) <= CMP_W'(tgt_s[k]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sat_s[k+1] <= sat_s[k];
				wt_s[k+1]  <= ok ? (wt_s[k] | (CH_W'(1) << B)) : wt_s[k];
			end
		end

		if (k < CH_W - 1) begin : g_fwd
			always_ff @(posedge clk) begin
				if (en) begin
					wr_s[k+1]  <= ok ? cand : wr_s[k];
					tgt_s[k+1] <= tgt_s[k];
					r_s[k+1]   <= r_s[k];
				end
			end
		end
	end

	assign out_valid = v_s[CH_W];
	assign w         = sat_s[CH_W] ? CH_MAX : wt_s[CH_W];

endmodule

// File: design/rgp_mix.sv
// Colour blend per channel, division by 255 and the output register.
module rgp_mix import rgp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [CH_W-1:0]     w,
	input  logic [COLOR_W-1:0]  outer_rgb,
	input  logic [COLOR_W-1:0]  inner_rgb,
	input  logic [OFFSET_W-1:0] rounding_offset,
	output logic                out_valid,
	output logic [CH_W-1:0]     red,
	output logic [CH_W-1:0]     green,
	output logic [CH_W-1:0]     blue
);

	logic             v_s1;
	logic [SUM_W-1:0] sum_s1 [0:NCH-1];
	logic             out_valid_q;
	logic [CH_W-1:0]  ch_q   [0:NCH-1];
	logic [CH_W-1:0]  w_inv;

	assign w_inv = CH_MAX - w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= in_valid;
			out_valid_q <= v_s1;
		end
	end

	for (genvar i = 0; i < NCH; i++) begin : g_ch
		localparam int LSB = CH_W * (NCH - 1 - i);
		logic [CH_W-1:0]  s, e;
		logic [SUM_W-1:0] sum;
		logic [QUO_W-1:0] q;

		assign s   = outer_rgb[LSB +: CH_W];
		assign e   = inner_rgb[LSB +: CH_W];
		assign sum = SUM_W'(s) * SUM_W'(w) + SUM_W'(e) * SUM_W'(w_inv)
			+ SUM_W'(rounding_offset);
		// floor(x/255) = (x + 1 + x/256) / 256, exact over the whole sum range
		assign q = (QUO_W'(sum_s1[i]) + QUO_W'(1) + QUO_W'(sum_s1[i] >> CH_W)) >> CH_W;

		always_ff @(posedge clk) begin
			if (en) begin
				sum_s1[i] <= sum;
				ch_q[i]   <= (q > QUO_W'(CH_MAX)) ? CH_MAX : CH_W'(q);
			end
		end
	end

	assign out_valid = out_valid_q;
	assign red       = ch_q[0];
	assign green     = ch_q[1];
	assign blue      = ch_q[2];

endmodule
